[hw/rtl/psl_pkg.sv]
// shared constants and types of the prime sieve lister
package psl_pkg;

  // field widths of the channels
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned PRIME_W = 9;
  localparam int unsigned INDEX_W = 7;

  // default largest limit, sets the depth of the candidate map
  localparam int unsigned MAX_LIMIT_DEF = 256;

  // smallest prime, first entry that the scan looks at
  localparam int unsigned FIRST_PRIME = 2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MARK,
    ST_FLUSH
  } state_e;

endpackage

[hw/rtl/psl_if.sv]
// channel interfaces of the prime sieve lister

// input channel: one upper limit per transaction
interface psl_in_if;
  logic                         valid;
  logic                         ready;
  logic [psl_pkg::LIMIT_W-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

// output channel: one prime per transaction
interface psl_out_if;
  logic                         valid;
  logic                         ready;
  logic [psl_pkg::PRIME_W-1:0] prime;
  logic [psl_pkg::INDEX_W-1:0] prime_index;
  logic                         none_found;
  logic                         last;

  modport source (output valid, output prime, output prime_index, output none_found,
                  output last, input ready);
  modport sink   (input valid, input prime, input prime_index, input none_found,
                  input last, output ready);
endinterface

[hw/rtl/prime_sieve_lister.sv]
// prime sieve lister: sieve of eratosthenes over a one-bit candidate memory
//
// in_i carries one upper limit n per transaction; limits above MaxLimit are
// saturated to MaxLimit. out_o returns the primes up to n in ascending
// order, each with its 1-based index; the final transaction of an item has
// last set, so its index is the prime count. A limit below two gives one
// transaction with none_found and last set and zero prime and index.
// One item at a time: in_i.ready is high only while the sequencer is idle.
// Work per item: the map is filled over entries 0 to n, each entry from 2
// to n is read and then checked, and each multiple of a prime p is marked
// with its own write (sum of n/p over primes p), set by the single write
// port and registered read of the map.
// Each prime is held back until the next one (or the end of the scan) is
// known, so that the last flag is exact; a stalled out_o receiver stalls
// the scan at the next prime found and holds the pending result.
// Reset returns the sequencer to idle and empties the output register; the
// map needs no clearing since every entry is filled before it is read.
module prime_sieve_lister #(
  parameter int unsigned MaxLimit = psl_pkg::MAX_LIMIT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  psl_in_if.sink            in_i,
  psl_out_if.source         out_o
);
  import psl_pkg::*;

  localparam int unsigned Depth = MaxLimit + 1;
  localparam int unsigned AW    = $clog2(Depth);

  localparam logic [LIMIT_W:0] MaxLimitW  = (LIMIT_W + 1)'(MaxLimit);
  localparam logic [AW-1:0]    FirstPrime = AW'(FIRST_PRIME);

  // sequencer and datapath registers
  state_e              state_q, state_d;
  logic [AW-1:0]       n_q, n_d;
  logic [AW-1:0]       i_q, i_d;
  logic [AW:0]         j_q, j_d;
  logic [PRIME_W-1:0]  pend_prime_q, pend_prime_d;
  logic [INDEX_W-1:0]  pend_index_q, pend_index_d;
  logic                pend_none_q, pend_none_d;
  logic                pend_valid_q, pend_valid_d;

  // output register
  logic                out_valid_q;
  logic [PRIME_W-1:0]  out_prime_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic                out_none_q;
  logic                out_last_q;

  // candidate map ports
  logic                mem_q [Depth];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                mem_wdata;
  logic                mem_re;
  logic                rdata_q;

  // control
  logic                in_ready;
  logic                out_free;
  logic                emit;
  logic                emit_last;
  logic [AW-1:0]       n_sat;
  logic [AW:0]         i_dbl;
  logic [AW:0]         j_next;
  logic                scan_done;

  assign out_free  = !out_valid_q || out_o.ready;
  assign n_sat     = ({1'b0, in_i.limit} > MaxLimitW) ? AW'(MaxLimit) : AW'(in_i.limit);
  assign i_dbl     = {1'b0, i_q} + {1'b0, i_q};
  assign j_next    = j_q + {1'b0, i_q};
  assign scan_done = (i_q == n_q);

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = i_q;
    mem_wdata = 1'b1;
    mem_re    = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SCAN_RD: begin
        mem_re = 1'b1;
      end
      ST_SCAN_CHK: begin
        emit = rdata_q && pend_valid_q && out_free;
      end
      ST_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[AW-1:0];
        mem_wdata = 1'b0;
      end
      ST_FLUSH: begin
        emit      = out_free;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    i_d          = i_q;
    j_d          = j_q;
    pend_prime_d = pend_prime_q;
    pend_index_d = pend_index_q;
    pend_none_d  = pend_none_q;
    pend_valid_d = pend_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          n_d          = n_sat;
          i_d          = '0;
          pend_prime_d = '0;
          pend_index_d = '0;
          pend_valid_d = 1'b0;
          if (n_sat < FirstPrime) begin
            pend_none_d = 1'b1;
            state_d     = ST_FLUSH;
          end else begin
            pend_none_d = 1'b0;
            state_d     = ST_CLEAR;
          end
        end
      end
      // fill entries 0..n with candidate
      ST_CLEAR: begin
        if (i_q == n_q) begin
          i_d     = FirstPrime;
          state_d = ST_SCAN_RD;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      // entry i is back from the map
      ST_SCAN_CHK: begin
        if (!rdata_q) begin
          if (scan_done) begin
            state_d = ST_FLUSH;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_SCAN_RD;
          end
        end else if (!pend_valid_q || out_free) begin
          pend_prime_d = PRIME_W'(i_q);
          pend_index_d = pend_index_q + 1'b1;
          pend_valid_d = 1'b1;
          j_d          = i_dbl;
          if (i_dbl <= {1'b0, n_q}) begin
            state_d = ST_MARK;
          end else if (scan_done) begin
            state_d = ST_FLUSH;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_SCAN_RD;
          end
        end
      end
      // mark multiples of i as composite
      ST_MARK: begin
        j_d = j_next;
        if (j_next > {1'b0, n_q}) begin
          if (scan_done) begin
            state_d = ST_FLUSH;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    i_q          <= i_d;
    j_q          <= j_d;
    pend_prime_q <= pend_prime_d;
    pend_index_q <= pend_index_d;
    pend_none_q  <= pend_none_d;
    if (emit) begin
      out_prime_q <= pend_prime_q;
      out_index_q <= pend_index_q;
      out_none_q  <= pend_none_q;
      out_last_q  <= emit_last;
    end
  end

  // candidate map, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[i_q];
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.prime       = out_prime_q;
  assign out_o.prime_index = out_index_q;
  assign out_o.none_found  = out_none_q;
  assign out_o.last        = out_last_q;

endmodule

[tb/sv/tb_top.sv]
// testbench of the prime sieve lister: random limits against a local sieve
`timescale 1ns / 1ps

module tb_top;
  import psl_pkg::*;

  localparam int unsigned SieveMax   = MAX_LIMIT_DEF;
  localparam int unsigned PrimeCap   = 64;
  localparam int unsigned RandItems  = 360;
  localparam int unsigned DrainWait  = 1500;
  localparam int unsigned CycleLimit = 4_000_000;

  // one limit to send, with its pacing
  typedef struct {
    logic [LIMIT_W-1:0] limit;
    bit                 drain_first;
    bit                 no_gap;
  } sieve_job_t;

  // one prime as the block should return it
  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [INDEX_W-1:0] prime_index;
    logic               none_found;
    logic               last;
  } prime_result_t;

  logic clk_i;
  logic rst_ni;

  psl_in_if  in_if ();
  psl_out_if out_if ();

  prime_sieve_lister dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sieve_job_t    pending_jobs[$];
  prime_result_t expected_primes[$];

  int unsigned job_total;
  int unsigned jobs_taken;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  bit in_taken;
  bit out_taken;

  // sender state
  sieve_job_t  cur_job;
  bit          job_staged;
  int unsigned send_gap;

  // receiver state
  bit          rx_calm;
  int unsigned rx_stall;

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sieve of eratosthenes up to the saturated limit, queues every prime
  task automatic predict_primes(input logic [LIMIT_W-1:0] lim);
    bit            composite [0:SieveMax];
    int unsigned   n;
    int unsigned   p;
    int unsigned   m;
    int unsigned   count;
    prime_result_t r;
    prime_result_t found[$];
    n = lim;
    if (n > SieveMax) n = SieveMax;
    if (n < FIRST_PRIME) begin
      r.prime       = '0;
      r.prime_index = '0;
      r.none_found  = 1'b1;
      r.last        = 1'b1;
      expected_primes = {expected_primes, r};
      return;
    end
    for (p = 0; p <= n; p++) composite[p] = 1'b0;
    count = 0;
    for (p = FIRST_PRIME; p <= n && count < PrimeCap; p++) begin
      if (!composite[p]) begin
        count++;
        r.prime       = PRIME_W'(p);
        r.prime_index = INDEX_W'(count);
        r.none_found  = 1'b0;
        r.last        = 1'b0;
        found = {found, r};
        for (m = p + p; m <= n; m += p) composite[m] = 1'b1;
      end
    end
    found[found.size()-1].last = 1'b1;
    foreach (found[k]) expected_primes = {expected_primes, found[k]};
  endtask

  // predict on accepted limits, check each accepted prime against the oldest one
  always @(posedge clk_i) begin
    prime_result_t want;
    in_taken  <= rst_ni && in_if.valid && in_if.ready;
    out_taken <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (in_if.valid && in_if.ready) begin
        predict_primes(in_if.limit);
        jobs_taken <= jobs_taken + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_primes.size() == 0) begin
          $error("unexpected transaction: prime %0d index %0d", out_if.prime,
                 out_if.prime_index);
          mismatch_count++;
        end else begin
          want = expected_primes.pop_front();
          if (out_if.prime !== want.prime) begin
            $error("prime: expected %0d, got %0d", want.prime, out_if.prime);
            mismatch_count++;
          end
          if (out_if.prime_index !== want.prime_index) begin
            $error("prime_index: expected %0d, got %0d", want.prime_index,
                   out_if.prime_index);
            mismatch_count++;
          end
          if (out_if.none_found !== want.none_found) begin
            $error("none_found: expected %0d, got %0d", want.none_found,
                   out_if.none_found);
            mismatch_count++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_if.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // sender: random gap before each limit unless no_gap is set, optional wait for all primes first
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) job_staged = 1'b0;
      if (!(in_if.valid && !in_taken)) begin
        if (!job_staged && pending_jobs.size() > 0) begin
          cur_job    = pending_jobs.pop_front();
          job_staged = 1'b1;
          send_gap   = cur_job.no_gap ? 0 : $urandom_range(0, 10);
        end
        if (job_staged && send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (job_staged && cur_job.drain_first && expected_primes.size() > 0) begin
          in_if.valid <= 1'b0;
        end else if (job_staged) begin
          in_if.valid <= 1'b1;
          in_if.limit <= cur_job.limit;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall after each transaction, calm stretches now and then
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_stall = rx_calm ? 0 : $urandom_range(0, 10);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [LIMIT_W-1:0] directed[$];
    sieve_job_t         job;
    bit                 calm;
    int unsigned        run_left;
    int unsigned        pick;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.limit    = '0;
    out_if.ready   = 1'b0;
    in_taken       = 1'b0;
    out_taken      = 1'b0;
    job_staged     = 1'b0;
    send_gap       = 0;
    rx_calm        = 1'b0;
    rx_stall       = 0;
    jobs_taken     = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    // directed: no prime, smallest primes, saturation, full width
    directed = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd0, 9'd7, 9'd31, 9'd32,
                 9'd97, 9'd100, 9'd128, 9'd255, 9'd256, 9'd257, 9'd511, 9'd1,
                 9'd311, 9'd256, 9'd2};
    foreach (directed[k]) begin
      job.limit       = directed[k];
      job.drain_first = (k == 8) || (k == 15);
      job.no_gap      = (k >= 4 && k < 11);
      pending_jobs    = {pending_jobs, job};
    end

    // random: small limits, full range with saturation, and limits up to 256
    calm     = 1'b0;
    run_left = $urandom_range(5, 30);
    for (int unsigned k = 0; k < RandItems; k++) begin
      if (run_left == 0) begin
        calm     = !calm;
        run_left = $urandom_range(5, 30);
      end
      run_left--;
      pick = $urandom_range(0, 9);
      if (pick < 4) job.limit = LIMIT_W'($urandom_range(0, 511));
      else if (pick < 8) job.limit = LIMIT_W'($urandom_range(0, 40));
      else job.limit = LIMIT_W'($urandom_range(0, 256));
      job.drain_first = ($urandom_range(0, 19) == 0);
      job.no_gap      = calm;
      pending_jobs    = {pending_jobs, job};
    end
    job_total = pending_jobs.size();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (jobs_taken < job_total || expected_primes.size() > 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    if (mismatch_count == 0 && expected_primes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/psl_pkg.sv
hw/rtl/psl_if.sv
hw/rtl/prime_sieve_lister.sv
tb/sv/tb_top.sv
